// ----- rtl/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared widths, codes and types of the table-driven bit permutation block.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 8;

    localparam int BYTE_W      = 8;
    localparam int BLOCK_W     = 64;
    localparam int INDEX_W     = 7;
    localparam int BYTES_CFG_W = 4;
    localparam int BIT_CNT_W   = 3;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [BIT_CNT_W-1:0]   LAST_BIT        = 3'd7;
    localparam logic [BYTES_CFG_W-1:0] BLOCK_BYTES_RST = 4'd8;

    // item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_INDEX = 1'b1;

    // register indexes, word address = 4 * index
    typedef enum logic [1:0] {
        REG_BLOCK_BYTES = 2'd0,
        REG_ONE_BASED   = 2'd1,
        REG_REVERSE     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BYTES_CFG_W-1:0] block_bytes;
        logic                   one_based;
        logic                   reverse_numbering;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              index_error;
        logic              last_byte;
    } result_t;

endpackage

// ----- rtl/tbp_if.sv -----
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels carrying input items and result bytes.
// ----------------------------------------------------------------------------
interface tbp_item_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [tbp_pkg::BLOCK_W-1:0]   block_data;
    logic [tbp_pkg::INDEX_W-1:0]   source_index;
    logic                          last_index;

    modport source (
        output valid, op, block_data, source_index, last_index,
        input  ready
    );
    modport sink (
        input  valid, op, block_data, source_index, last_index,
        output ready
    );
endinterface

interface tbp_result_if;
    logic                          valid;
    logic                          ready;
    logic [tbp_pkg::BYTE_W-1:0]    out_byte;
    logic                          index_error;
    logic                          last_byte;

    modport source (
        output valid, out_byte, index_error, last_byte,
        input  ready
    );
    modport sink (
        input  valid, out_byte, index_error, last_byte,
        output ready
    );
endinterface

// ----- rtl/tbp_core.sv -----
// ----------------------------------------------------------------------------
// tbp_core
// Source block store, bit select and byte packing for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module tbp_core #(
    parameter int MAX_BLOCK_BYTES = tbp_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbp_pkg::cfg_t                cfg,
    input  logic                         fire,
    input  logic                         op,
    input  logic [tbp_pkg::BLOCK_W-1:0]  block_data,
    input  logic [tbp_pkg::INDEX_W-1:0]  source_index,
    input  logic                         last_index,
    output logic                         res_valid,
    output tbp_pkg::result_t             res
);
    import tbp_pkg::*;

    localparam int SRC_W = MAX_BLOCK_BYTES * BYTE_W;
    localparam int POS_W = $clog2(SRC_W);
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(SRC_W - 1);
    localparam logic [BYTES_CFG_W-1:0] MAX_BYTES = BYTES_CFG_W'(MAX_BLOCK_BYTES);

    logic [SRC_W-1:0]     source_block_reg, source_block_next;
    logic [BYTE_W-1:0]    pack_byte_reg, pack_byte_next;
    logic [BIT_CNT_W-1:0] bits_packed_reg, bits_packed_next;
    logic                 error_pending_reg, error_pending_next;

    logic [BYTES_CFG_W-1:0] bytes_eff;
    logic [INDEX_W-1:0]     nbits;
    logic [INDEX_W-1:0]     bit_num;
    logic [INDEX_W-1:0]     pos_full;
    logic [POS_W-1:0]       pos;
    logic                   bad;
    logic                   sel_bit;
    logic [BYTE_W-1:0]      pack_now;
    logic                   close;

    always_comb
    begin
        if (cfg.block_bytes == '0)
            bytes_eff = BYTES_CFG_W'(1);
        else if (cfg.block_bytes > MAX_BYTES)
            bytes_eff = MAX_BYTES;
        else
            bytes_eff = cfg.block_bytes;

        nbits   = {bytes_eff[BYTES_CFG_W-1:0], 3'b000};
        bit_num = source_index - INDEX_W'(cfg.one_based);
        bad     = (cfg.one_based && source_index == '0) || (bit_num >= nbits);

        // reverse mode counts from the lsb of the last valid byte
        if (cfg.reverse_numbering)
            pos_full = nbits - INDEX_W'(1) - bit_num;
        else
            pos_full = bit_num;
        pos = pos_full[POS_W-1:0];

        sel_bit  = !bad && source_block_reg[TOP_POS - pos];
        pack_now = pack_byte_reg | (BYTE_W'(sel_bit) << (LAST_BIT - bits_packed_reg));
        close    = (bits_packed_reg == LAST_BIT) || last_index;

        source_block_next  = source_block_reg;
        pack_byte_next     = pack_byte_reg;
        bits_packed_next   = bits_packed_reg;
        error_pending_next = error_pending_reg;
        res_valid          = 1'b0;

        if (fire)
        begin
            if (op == OP_LOAD)
            begin
                source_block_next = block_data[BLOCK_W-1 -: SRC_W];
            end
            else if (close)
            begin
                res_valid          = 1'b1;
                pack_byte_next     = '0;
                bits_packed_next   = '0;
                error_pending_next = 1'b0;
            end
            else
            begin
                pack_byte_next     = pack_now;
                bits_packed_next   = bits_packed_reg + BIT_CNT_W'(1);
                error_pending_next = error_pending_reg | bad;
            end
        end

        res.out_byte    = pack_now;
        res.index_error = error_pending_reg | bad;
        res.last_byte   = last_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_block_reg  <= '0;
            pack_byte_reg     <= '0;
            bits_packed_reg   <= '0;
            error_pending_reg <= 1'b0;
        end
        else
        begin
            source_block_reg  <= source_block_next;
            pack_byte_reg     <= pack_byte_next;
            bits_packed_reg   <= bits_packed_next;
            error_pending_reg <= error_pending_next;
        end
    end

endmodule

// ----- rtl/table_bit_permutation_top.sv -----
// ----------------------------------------------------------------------------
// table_bit_permutation_top
// Table-driven bit permutation with APB register port and output buffer.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless the input stalls. A load item
// replaces the source block; an index item picks one source bit and packs
// it into the current byte. The eighth index, or the index marked last,
// closes the byte, which appears on the result channel the cycle after that
// index was accepted unless an earlier byte is still waiting there. A
// two-entry output buffer lets the input keep flowing while a byte waits;
// the input stalls only when both entries hold bytes not yet taken.
// Registers: block_bytes at 0x0, one_based at 0x4, reverse_numbering at 0x8.
module table_bit_permutation_top #(
    parameter int MAX_BLOCK_BYTES = tbp_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tbp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tbp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    tbp_item_if.sink                         item,
    tbp_result_if.source                     result
);
    import tbp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    logic     fire;
    logic     res_valid;
    result_t  res;

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    result_t  out_res_reg, out_res_next;
    result_t  skid_res_reg, skid_res_next;
    logic     take;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_bytes       <= BLOCK_BYTES_RST;
            cfg_reg.one_based         <= 1'b0;
            cfg_reg.reverse_numbering <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_BLOCK_BYTES: cfg_reg.block_bytes       <= pwdata[BYTES_CFG_W-1:0];
                REG_ONE_BASED:   cfg_reg.one_based         <= pwdata[0];
                REG_REVERSE:     cfg_reg.reverse_numbering <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BLOCK_BYTES: prdata = CFG_DATA_W'(cfg_reg.block_bytes);
            REG_ONE_BASED:   prdata = CFG_DATA_W'(cfg_reg.one_based);
            REG_REVERSE:     prdata = CFG_DATA_W'(cfg_reg.reverse_numbering);
            default:         prdata = '0;
        endcase
    end

    // datapath
    assign item.ready = !skid_valid_reg;
    assign fire       = item.valid && item.ready;

    tbp_core #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (fire),
        .op           (item.op),
        .block_data   (item.block_data),
        .source_index (item.source_index),
        .last_index   (item.last_index),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output register with skid entry
    assign take = out_valid_reg && result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;

        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (res_valid)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_res_reg.out_byte;
    assign result.index_error = out_res_reg.index_error;
    assign result.last_byte   = out_res_reg.last_byte;

`ifndef NO_ASSERTIONS
    // skid entry only fills behind a waiting output byte
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a byte while output register is empty");

    // after a last index the result channel always holds a byte next cycle
    a_last_yields_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_INDEX && item.last_index) |=> out_valid_reg)
        else $error("last index did not produce an output byte");

    // a load transfer with no take neither adds nor removes a buffered byte
    a_load_no_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_LOAD && !take) |=>
            (out_valid_reg == $past(out_valid_reg) &&
             skid_valid_reg == $past(skid_valid_reg)))
        else $error("load transfer changed output buffer occupancy");
`endif

endmodule

// ----- tb/sv/tbp_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_tb_pkg
// Scoreboard of the bit permutation bench: it predicts each packed byte from
// the accepted items and checks the bytes that the block hands back.
// ----------------------------------------------------------------------------
package tbp_tb_pkg;

    class perm_scoreboard;
        logic [tbp_pkg::BYTES_CFG_W-1:0] blk_bytes;
        logic                            one_based;
        logic                            reverse;
        logic [tbp_pkg::BLOCK_W-1:0]     src_block;
        logic [tbp_pkg::BYTE_W-1:0]      acc_byte;
        logic [tbp_pkg::BIT_CNT_W-1:0]   acc_count;
        logic                            acc_error;
        tbp_pkg::result_t                expected_bytes[$];
        int unsigned                     failures;

        function new();
            blk_bytes = tbp_pkg::BLOCK_BYTES_RST;
            one_based = 1'b0;
            reverse   = 1'b0;
            src_block = '0;
            acc_byte  = '0;
            acc_count = '0;
            acc_error = 1'b0;
            failures  = 0;
        endfunction

        function void set_reg(tbp_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                tbp_pkg::REG_BLOCK_BYTES: blk_bytes = value[tbp_pkg::BYTES_CFG_W-1:0];
                tbp_pkg::REG_ONE_BASED:   one_based = value[0];
                tbp_pkg::REG_REVERSE:     reverse   = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_bytes.size();
        endfunction

        // one accepted item: a load swaps the block, an index packs one bit
        function void note_item(logic op, logic [tbp_pkg::BLOCK_W-1:0] data,
                                logic [tbp_pkg::INDEX_W-1:0] idx, logic last);
            int unsigned      nbytes;
            int unsigned      nbits;
            int unsigned      num;
            int unsigned      pos;
            logic             sel_bit;
            logic             bad;
            tbp_pkg::result_t packed_res;

            if (op == tbp_pkg::OP_LOAD)
            begin
                src_block = data;
                return;
            end
            nbytes = blk_bytes;
            if (nbytes < 1)
                nbytes = 1;
            if (nbytes > tbp_pkg::MAX_BLOCK_BYTES_DEF)
                nbytes = tbp_pkg::MAX_BLOCK_BYTES_DEF;
            nbits   = nbytes * 8;
            sel_bit = 1'b0;
            bad     = 1'b0;
            if (one_based && idx == 0)
                bad = 1'b1;
            else
            begin
                num = idx - one_based;
                if (num >= nbits)
                    bad = 1'b1;
                else
                begin
                    pos     = reverse ? nbits - 1 - num : num;
                    sel_bit = src_block[63 - pos];
                end
            end
            acc_byte[7 - acc_count] = acc_byte[7 - acc_count] | sel_bit;
            acc_error = acc_error | bad;
            if (acc_count == tbp_pkg::LAST_BIT || last)
            begin
                packed_res.out_byte    = acc_byte;
                packed_res.index_error = acc_error;
                packed_res.last_byte   = last;
                expected_bytes = {expected_bytes, packed_res};
                acc_byte  = '0;
                acc_count = '0;
                acc_error = 1'b0;
            end
            else
                acc_count = acc_count + 1'b1;
        endfunction

        function void check_byte(logic [tbp_pkg::BYTE_W-1:0] got_byte, logic got_err,
                                 logic got_last);
            tbp_pkg::result_t want;

            if (expected_bytes.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected byte: out_byte %02h index_error %0b last_byte %0b",
                         $time, got_byte, got_err, got_last);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.out_byte !== got_byte)
            begin
                failures++;
                $display("%0t: out_byte expected %02h actual %02h",
                         $time, want.out_byte, got_byte);
            end
            if (want.index_error !== got_err)
            begin
                failures++;
                $display("%0t: index_error expected %0b actual %0b",
                         $time, want.index_error, got_err);
            end
            if (want.last_byte !== got_last)
            begin
                failures++;
                $display("%0t: last_byte expected %0b actual %0b",
                         $time, want.last_byte, got_last);
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench of table_bit_permutation_top: directed and random loads and index
// items under several register settings and idle patterns, each result byte
// checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbp_tb_pkg::*;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tbp_pkg::CFG_ADDR_W-1:0] paddr;
    logic [tbp_pkg::CFG_DATA_W-1:0] pwdata;
    logic [tbp_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    tbp_item_if   item_ch();
    tbp_result_if result_ch();

    perm_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned cur_bytes;
    logic        cur_one_based;

    table_bit_permutation_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_item(logic op, logic [tbp_pkg::BLOCK_W-1:0] data,
                             logic [tbp_pkg::INDEX_W-1:0] idx, logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.block_data   <= data;
        item_ch.source_index <= idx;
        item_ch.last_index   <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(op, data, idx, last);
    endtask

    // drop valid and let every expected byte come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(tbp_pkg::reg_idx_t idx, logic [3:0] value);
        logic [31:0] wdata;

        wdata = $urandom();
        if (idx == tbp_pkg::REG_BLOCK_BYTES)
            wdata[3:0] = value;
        else
            wdata[0] = value[0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, wdata);
    endtask

    task automatic configure(logic [3:0] bb, logic ob, logic rv, int mode);
        drain();
        write_reg(tbp_pkg::REG_BLOCK_BYTES, bb);
        write_reg(tbp_pkg::REG_ONE_BASED, {3'b000, ob});
        write_reg(tbp_pkg::REG_REVERSE, {3'b000, rv});
        cur_bytes     = (bb == 0) ? 1 : (bb > 8 ? 8 : bb);
        cur_one_based = ob;
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    // result side: check each transfer, then pick the next ready
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_byte(result_ch.out_byte, result_ch.index_error,
                              result_ch.last_byte);
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        logic [3:0]                  phase_bytes[8] = '{4'd8, 4'd1, 4'd4, 4'd8,
                                                        4'd0, 4'd15, 4'd3, 4'd2};
        logic                        phase_ob[8]    = '{1'b0, 1'b1, 1'b0, 1'b1,
                                                        1'b1, 1'b0, 1'b1, 1'b0};
        logic                        phase_rv[8]    = '{1'b0, 1'b0, 1'b1, 1'b1,
                                                        1'b1, 1'b1, 1'b0, 1'b1};
        logic [tbp_pkg::BLOCK_W-1:0] data;
        logic [tbp_pkg::INDEX_W-1:0] idx;
        int unsigned                 kind;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.op           = tbp_pkg::OP_LOAD;
        item_ch.block_data   = '0;
        item_ch.source_index = '0;
        item_ch.last_index   = 1'b0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // forward, zero-based, full block: range edges and a mid-table load
        configure(4'd8, 1'b0, 1'b0, 0);
        send_item(tbp_pkg::OP_LOAD, 64'hA5C3_0F1E_7B96_D248, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd63, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd64, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd127, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd7, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd56, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd1, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd2, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd5, 1'b0);
        send_item(tbp_pkg::OP_LOAD, '1, 7'd127, 1'b1);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd62, 1'b1);

        // one byte, one-based, reversed: zero index and just past the end
        configure(4'd1, 1'b1, 1'b1, 0);
        send_item(tbp_pkg::OP_LOAD, 64'h0123_4567_89AB_CDEF, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd1, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd8, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd9, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd127, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd3, 1'b1);

        // block size zero acts as one byte
        configure(4'd0, 1'b0, 1'b0, 0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd7, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd8, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd0, 1'b1);

        // block size above eight acts as eight, reversed
        configure(4'd15, 1'b0, 1'b1, 0);
        send_item(tbp_pkg::OP_LOAD, 64'hA5C3_0F1E_7B96_D248, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd0, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd63, 1'b0);
        send_item(tbp_pkg::OP_INDEX, '0, 7'd64, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            configure(phase_bytes[ph], phase_ob[ph], phase_rv[ph], ph % 4);
            for (int n = 0; n < 66; n++)
            begin
                kind = $urandom_range(99);
                data = {$urandom(), $urandom()};
                if (kind < 2)
                    data = '0;
                else if (kind < 4)
                    data = '1;
                if (kind < 12)
                    send_item(tbp_pkg::OP_LOAD, data, 7'($urandom_range(127)),
                              1'($urandom_range(1)));
                else
                begin
                    // mostly valid bit numbers, some anywhere in the field
                    if ($urandom_range(99) < 80)
                        idx = 7'($urandom_range(cur_bytes * 8 - 1) + cur_one_based);
                    else
                        idx = 7'($urandom_range(127));
                    send_item(tbp_pkg::OP_INDEX, data, idx, $urandom_range(9) == 0);
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
